// ===== sv/dtp_pkg.sv =====
package dtp_pkg;

    localparam int CHAR_W = 8;
    localparam int SIG_W  = 60;
    localparam int EXP_W  = 15;
    localparam int EXPV_W = 14;
    localparam int KEPT_W = 5;
    // Width of the exponent sum before saturation.
    localparam int ESUM_W = EXP_W + 2;
    // Width of exp_value * 10 + digit.
    localparam int EPROD_W = EXPV_W + 4;

    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_E   = 8'h45;
    localparam logic [CHAR_W-1:0] CH_LO_E   = 8'h65;

    localparam logic signed [EXP_W-1:0] EXP_MIN = 15'sh4000;
    localparam logic signed [EXP_W-1:0] EXP_MAX = 15'sh3FFF;

    typedef enum logic [2:0] {
        PH_WS,
        PH_INT,
        PH_FRAC,
        PH_ESIGN,
        PH_EDIG,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              line_end;
    } dtp_item_t;

    // Packed so that is_negative lands in the lowest bit.
    typedef struct packed {
        logic              exp_clipped;
        logic              digits_cut;
        logic              found_digits;
        logic [EXP_W-1:0]  dec_exponent;
        logic [SIG_W-1:0]  significand;
        logic              is_negative;
    } dtp_result_t;

endpackage

// ===== sv/dtp_in_reg.sv =====
module dtp_in_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dtp_pkg::dtp_item_t in_item,
    input  logic              take,
    output logic              item_valid,
    output dtp_pkg::dtp_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    dtp_pkg::dtp_item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== sv/dtp_core.sv =====
module dtp_core
#(
    parameter int MAX_SIG_DIGITS = 18,
    parameter int MAX_EXP_VALUE  = 9999
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  dtp_pkg::dtp_item_t   item,
    output dtp_pkg::dtp_result_t result
);

    dtp_pkg::phase_t                    phase_reg, phase_next;
    logic                               neg_reg, neg_next;
    logic [dtp_pkg::SIG_W-1:0]          acc_reg, acc_next;
    logic [dtp_pkg::KEPT_W-1:0]         kept_reg, kept_next;
    logic signed [dtp_pkg::EXP_W-1:0]   adj_reg, adj_next;
    logic [dtp_pkg::EXPV_W-1:0]         ev_reg, ev_next;
    logic                               eneg_reg, eneg_next;
    logic                               seen_reg, seen_next;
    logic                               cut_reg, cut_next;
    logic                               clip_reg, clip_next;

    logic [dtp_pkg::CHAR_W-1:0]         ch;
    logic [3:0]                         d;
    logic                               is_dig, is_blank, is_emark;
    logic                               mant_dig, in_frac, lead_zero, keep, drop;
    logic                               adj_inc, adj_dec, adj_sat;
    logic                               exp_dig, exp_sat;
    logic [dtp_pkg::EPROD_W-1:0]        ev_wide, ev_prod;
    logic signed [dtp_pkg::ESUM_W-1:0]  e_sum;
    logic signed [dtp_pkg::EXP_W-1:0]   e_final;
    logic                               e_sat;

    assign ch       = item.char_code;
    assign d        = ch[3:0];
    assign is_dig   = (ch >= dtp_pkg::CH_ZERO) && (ch <= dtp_pkg::CH_NINE);
    assign is_blank = (ch == dtp_pkg::CH_SPACE)
                   || ((ch >= dtp_pkg::CH_TAB) && (ch <= dtp_pkg::CH_CR));
    assign is_emark = (ch == dtp_pkg::CH_LO_E) || (ch == dtp_pkg::CH_UP_E);

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            dtp_pkg::PH_WS:
            begin
                priority if (is_blank)                  phase_next = dtp_pkg::PH_WS;
                else if (ch == dtp_pkg::CH_MINUS)       phase_next = dtp_pkg::PH_INT;
                else if (ch == dtp_pkg::CH_PLUS)        phase_next = dtp_pkg::PH_INT;
                else if (is_dig)                        phase_next = dtp_pkg::PH_INT;
                else if (ch == dtp_pkg::CH_POINT)       phase_next = dtp_pkg::PH_FRAC;
                else if (is_emark)                      phase_next = dtp_pkg::PH_ESIGN;
                else                                    phase_next = dtp_pkg::PH_DONE;
            end
            dtp_pkg::PH_INT:
            begin
                priority if (is_dig)                    phase_next = dtp_pkg::PH_INT;
                else if (ch == dtp_pkg::CH_POINT)       phase_next = dtp_pkg::PH_FRAC;
                else if (is_emark)                      phase_next = dtp_pkg::PH_ESIGN;
                else                                    phase_next = dtp_pkg::PH_DONE;
            end
            dtp_pkg::PH_FRAC:
            begin
                priority if (is_dig)                    phase_next = dtp_pkg::PH_FRAC;
                else if (is_emark)                      phase_next = dtp_pkg::PH_ESIGN;
                else                                    phase_next = dtp_pkg::PH_DONE;
            end
            dtp_pkg::PH_ESIGN:
            begin
                priority if (ch == dtp_pkg::CH_MINUS)   phase_next = dtp_pkg::PH_EDIG;
                else if (ch == dtp_pkg::CH_PLUS)        phase_next = dtp_pkg::PH_EDIG;
                else if (is_dig)                        phase_next = dtp_pkg::PH_EDIG;
                else                                    phase_next = dtp_pkg::PH_DONE;
            end
            dtp_pkg::PH_EDIG:
            begin
                priority if (is_dig)                    phase_next = dtp_pkg::PH_EDIG;
                else                                    phase_next = dtp_pkg::PH_DONE;
            end
            default:
            begin
                phase_next = dtp_pkg::PH_DONE;
            end
        endcase
    end

    assign neg_next  = neg_reg  || ((phase_reg == dtp_pkg::PH_WS) && (ch == dtp_pkg::CH_MINUS));
    assign eneg_next = eneg_reg
                    || ((phase_reg == dtp_pkg::PH_ESIGN) && (ch == dtp_pkg::CH_MINUS));

    // The accumulator is zero exactly while no digit has been kept, so the
    // leading-zero test looks at the count and not at the wrapped 60-bit value.
    assign in_frac   = (phase_reg == dtp_pkg::PH_FRAC);
    assign mant_dig  = is_dig && ((phase_reg == dtp_pkg::PH_WS)
                    || (phase_reg == dtp_pkg::PH_INT) || in_frac);
    assign lead_zero = (kept_reg == '0) && (d == 4'd0);
    assign keep      = mant_dig && !lead_zero
                    && (kept_reg < dtp_pkg::KEPT_W'(MAX_SIG_DIGITS));
    assign drop      = mant_dig && !lead_zero && !keep;

    assign acc_next  = keep ? ((acc_reg << 3) + (acc_reg << 1)
                              + {{(dtp_pkg::SIG_W-4){1'b0}}, d}) : acc_reg;
    assign kept_next = keep ? kept_reg + 1'b1 : kept_reg;
    assign seen_next = seen_reg || mant_dig;
    assign cut_next  = cut_reg || drop;

    assign adj_dec = mant_dig && in_frac && (lead_zero || keep);
    assign adj_inc = drop && !in_frac;

    always_comb
    begin
        adj_next = adj_reg;
        adj_sat  = 1'b0;
        priority if (adj_inc)
        begin
            if (adj_reg == dtp_pkg::EXP_MAX) adj_sat = 1'b1;
            else                             adj_next = adj_reg + dtp_pkg::EXP_W'(1);
        end
        else if (adj_dec)
        begin
            if (adj_reg == dtp_pkg::EXP_MIN) adj_sat = 1'b1;
            else                             adj_next = adj_reg - dtp_pkg::EXP_W'(1);
        end
        else
        begin
            adj_next = adj_reg;
        end
    end

    assign exp_dig = is_dig && ((phase_reg == dtp_pkg::PH_ESIGN)
                  || (phase_reg == dtp_pkg::PH_EDIG));
    assign ev_wide = {{(dtp_pkg::EPROD_W-dtp_pkg::EXPV_W){1'b0}}, ev_reg};
    assign ev_prod = (ev_wide << 3) + (ev_wide << 1)
                   + {{(dtp_pkg::EPROD_W-4){1'b0}}, d};
    assign exp_sat = exp_dig && (ev_prod > dtp_pkg::EPROD_W'(MAX_EXP_VALUE));

    always_comb
    begin
        priority if (exp_sat) ev_next = dtp_pkg::EXPV_W'(MAX_EXP_VALUE);
        else if (exp_dig)     ev_next = ev_prod[dtp_pkg::EXPV_W-1:0];
        else                  ev_next = ev_reg;
    end

    assign clip_next = clip_reg || adj_sat || exp_sat;

    // Final exponent from the state as it stands after this character.
    always_comb
    begin
        if (eneg_next)
        begin
            e_sum = dtp_pkg::ESUM_W'(adj_next)
                  - $signed({{(dtp_pkg::ESUM_W-dtp_pkg::EXPV_W){1'b0}}, ev_next});
        end
        else
        begin
            e_sum = dtp_pkg::ESUM_W'(adj_next)
                  + $signed({{(dtp_pkg::ESUM_W-dtp_pkg::EXPV_W){1'b0}}, ev_next});
        end
        e_sat = 1'b0;
        priority if (e_sum > dtp_pkg::ESUM_W'(dtp_pkg::EXP_MAX))
        begin
            e_final = dtp_pkg::EXP_MAX;
            e_sat   = 1'b1;
        end
        else if (e_sum < dtp_pkg::ESUM_W'(dtp_pkg::EXP_MIN))
        begin
            e_final = dtp_pkg::EXP_MIN;
            e_sat   = 1'b1;
        end
        else
        begin
            e_final = e_sum[dtp_pkg::EXP_W-1:0];
        end
    end

    always_comb
    begin
        result.is_negative  = neg_next;
        result.significand  = seen_next ? acc_next : '0;
        result.dec_exponent = seen_next ? e_final : '0;
        result.found_digits = seen_next;
        result.digits_cut   = cut_next;
        result.exp_clipped  = clip_next || e_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dtp_pkg::PH_WS;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            kept_reg  <= '0;
            adj_reg   <= '0;
            ev_reg    <= '0;
            eneg_reg  <= 1'b0;
            seen_reg  <= 1'b0;
            cut_reg   <= 1'b0;
            clip_reg  <= 1'b0;
        end
        else if (step)
        begin
            if (item.line_end)
            begin
                phase_reg <= dtp_pkg::PH_WS;
                neg_reg   <= 1'b0;
                acc_reg   <= '0;
                kept_reg  <= '0;
                adj_reg   <= '0;
                ev_reg    <= '0;
                eneg_reg  <= 1'b0;
                seen_reg  <= 1'b0;
                cut_reg   <= 1'b0;
                clip_reg  <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
                kept_reg  <= kept_next;
                adj_reg   <= adj_next;
                ev_reg    <= ev_next;
                eneg_reg  <= eneg_next;
                seen_reg  <= seen_next;
                cut_reg   <= cut_next;
                clip_reg  <= clip_next;
            end
        end
    end

    a_kept_limit: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= dtp_pkg::KEPT_W'(MAX_SIG_DIGITS))
        else $error("kept digit count above limit");

    a_exp_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ev_reg <= dtp_pkg::EXPV_W'(MAX_EXP_VALUE))
        else $error("exponent digits above limit");

    a_acc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (kept_reg == '0) |-> (acc_reg == '0))
        else $error("accumulator nonzero with no kept digits");

    a_line_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.line_end) |=> ((phase_reg == dtp_pkg::PH_WS) && (kept_reg == '0)
                                     && !seen_reg && !clip_reg))
        else $error("state not cleared after end of line");

endmodule

// ===== sv/dtp_out_reg.sv =====
module dtp_out_reg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  dtp_pkg::dtp_result_t result,
    output logic                 free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dtp_pkg::dtp_result_t out_result
);

    logic                 valid_reg;
    logic                 valid_next;
    dtp_pkg::dtp_result_t result_reg;

    // The register can take a new result when empty or while the held one is taken.
    assign free       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// ===== sv/decimal_number_text_parser.sv =====
// Path: a character waits in the input register until the core parses it; for the last
// character of a line the result enters the output register as the core parses it.
// Throughput: one character per cycle; only the end-of-line request waits on a full
// output register, other characters pass through the single parse stage.
// Reset: rst_n is asynchronous and active low; it empties both registers and
// returns the parser to the whitespace phase with all accumulators cleared.
module decimal_number_text_parser
#(
    parameter int MAX_SIG_DIGITS = 18,
    parameter int MAX_EXP_VALUE  = 9999
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // line_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] is_negative, [60:1] significand, [75:61] dec_exponent,
    // [76] found_digits, [77] digits_cut, [78] exp_clipped, [79] zero
    output logic [79:0] m_axis_tdata
);

    dtp_pkg::dtp_item_t   in_item;
    dtp_pkg::dtp_item_t   item;
    dtp_pkg::dtp_result_t result;
    dtp_pkg::dtp_result_t out_result;
    logic                 item_valid;
    logic                 out_free;
    logic                 take;

    assign in_item.char_code = s_axis_tdata;
    assign in_item.line_end  = s_axis_tlast;

    // Characters inside a line never wait; the last one needs room for its result.
    assign take = item_valid && (!item.line_end || out_free);

    dtp_in_reg u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    dtp_core
    #(
        .MAX_SIG_DIGITS (MAX_SIG_DIGITS),
        .MAX_EXP_VALUE  (MAX_EXP_VALUE)
    )
    u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (take),
        .item   (item),
        .result (result)
    );

    dtp_out_reg u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take && item.line_end),
        .result     (result),
        .free       (out_free),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    assign m_axis_tdata = {1'b0, out_result};

endmodule

// ===== test/decimal_number_text_parser_tb.sv =====
`timescale 1ns / 100ps

module decimal_number_text_parser_tb;

    localparam int MAX_SIG_DIGITS = 18;
    localparam int MAX_EXP_VALUE  = 9999;
    localparam int RANDOM_CHARS   = 1200;
    localparam int CALM_CHARS     = 1000;
    localparam int HOLD_CYCLES    = 200;

    // Tracks the parse of the current line and keeps the numbers still owed by the block.
    class number_scoreboard;
        dtp_pkg::dtp_result_t expected_numbers[$];
        int                   errors;
        dtp_pkg::phase_t      stage;
        logic                 negative;
        logic                 exp_negative;
        logic                 seen_digit;
        logic                 cut;
        logic                 clip;
        logic [63:0]          acc;
        int                   kept;
        int                   exp_adjust;
        int                   exp_value;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            stage        = dtp_pkg::PH_WS;
            negative     = 1'b0;
            exp_negative = 1'b0;
            seen_digit   = 1'b0;
            cut          = 1'b0;
            clip         = 1'b0;
            acc          = '0;
            kept         = 0;
            exp_adjust   = 0;
            exp_value    = 0;
        endfunction

        function void shift_exponent(int delta);
            int v;
            v = exp_adjust + delta;
            if (v > int'(dtp_pkg::EXP_MAX))
            begin
                v    = int'(dtp_pkg::EXP_MAX);
                clip = 1'b1;
            end
            if (v < int'(dtp_pkg::EXP_MIN))
            begin
                v    = int'(dtp_pkg::EXP_MIN);
                clip = 1'b1;
            end
            exp_adjust = v;
        endfunction

        function void mantissa_digit(int d, bit in_fraction);
            seen_digit = 1'b1;
            // Leading zeros never use up a kept digit.
            if (acc == 0 && d == 0)
            begin
                if (in_fraction)
                    shift_exponent(-1);
            end
            else if (kept < MAX_SIG_DIGITS)
            begin
                acc  = acc * 10 + 64'(d);
                kept = kept + 1;
                if (in_fraction)
                    shift_exponent(-1);
            end
            else
            begin
                cut = 1'b1;
                if (!in_fraction)
                    shift_exponent(1);
            end
        endfunction

        function void exponent_digit(int d);
            int v;
            v = exp_value * 10 + d;
            if (v > MAX_EXP_VALUE)
            begin
                v    = MAX_EXP_VALUE;
                clip = 1'b1;
            end
            exp_value = v;
        endfunction

        function void parse_char(logic [7:0] c, logic last);
            logic                 dig;
            logic                 emark;
            int                   d;
            int                   e;
            dtp_pkg::dtp_result_t r;
            dig   = (c >= dtp_pkg::CH_ZERO) && (c <= dtp_pkg::CH_NINE);
            emark = (c == dtp_pkg::CH_LO_E) || (c == dtp_pkg::CH_UP_E);
            d     = int'(c) - int'(dtp_pkg::CH_ZERO);
            case (stage)
                dtp_pkg::PH_WS:
                begin
                    if (!(c == dtp_pkg::CH_SPACE
                          || (c >= dtp_pkg::CH_TAB && c <= dtp_pkg::CH_CR)))
                    begin
                        if (c == dtp_pkg::CH_MINUS)
                        begin
                            negative = 1'b1;
                            stage    = dtp_pkg::PH_INT;
                        end
                        else if (c == dtp_pkg::CH_PLUS)
                            stage = dtp_pkg::PH_INT;
                        else if (dig)
                        begin
                            mantissa_digit(d, 1'b0);
                            stage = dtp_pkg::PH_INT;
                        end
                        else if (c == dtp_pkg::CH_POINT)
                            stage = dtp_pkg::PH_FRAC;
                        else if (emark)
                            stage = dtp_pkg::PH_ESIGN;
                        else
                            stage = dtp_pkg::PH_DONE;
                    end
                end
                dtp_pkg::PH_INT:
                begin
                    if (dig)
                        mantissa_digit(d, 1'b0);
                    else if (c == dtp_pkg::CH_POINT)
                        stage = dtp_pkg::PH_FRAC;
                    else if (emark)
                        stage = dtp_pkg::PH_ESIGN;
                    else
                        stage = dtp_pkg::PH_DONE;
                end
                dtp_pkg::PH_FRAC:
                begin
                    if (dig)
                        mantissa_digit(d, 1'b1);
                    else if (emark)
                        stage = dtp_pkg::PH_ESIGN;
                    else
                        stage = dtp_pkg::PH_DONE;
                end
                dtp_pkg::PH_ESIGN:
                begin
                    if (c == dtp_pkg::CH_MINUS)
                    begin
                        exp_negative = 1'b1;
                        stage        = dtp_pkg::PH_EDIG;
                    end
                    else if (c == dtp_pkg::CH_PLUS)
                        stage = dtp_pkg::PH_EDIG;
                    else if (dig)
                    begin
                        exponent_digit(d);
                        stage = dtp_pkg::PH_EDIG;
                    end
                    else
                        stage = dtp_pkg::PH_DONE;
                end
                dtp_pkg::PH_EDIG:
                begin
                    if (dig)
                        exponent_digit(d);
                    else
                        stage = dtp_pkg::PH_DONE;
                end
                default:
                    stage = dtp_pkg::PH_DONE;
            endcase

            if (last)
            begin
                e = exp_adjust + (exp_negative ? -exp_value : exp_value);
                if (e > int'(dtp_pkg::EXP_MAX))
                begin
                    e    = int'(dtp_pkg::EXP_MAX);
                    clip = 1'b1;
                end
                if (e < int'(dtp_pkg::EXP_MIN))
                begin
                    e    = int'(dtp_pkg::EXP_MIN);
                    clip = 1'b1;
                end
                r              = '0;
                r.is_negative  = negative;
                r.found_digits = seen_digit;
                r.digits_cut   = cut;
                r.exp_clipped  = clip;
                if (seen_digit)
                begin
                    r.significand  = acc[dtp_pkg::SIG_W-1:0];
                    r.dec_exponent = e[dtp_pkg::EXP_W-1:0];
                end
                expected_numbers.push_back(r);
                clear();
            end
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got)
            begin
                errors = errors + 1;
                $error("%s: expected %0d, actual %0d", name, want, got);
            end
        endfunction

        function void check_number(dtp_pkg::dtp_result_t got);
            dtp_pkg::dtp_result_t want;
            if (expected_numbers.size() == 0)
            begin
                errors = errors + 1;
                $error("number returned while none was expected");
            end
            else
            begin
                want = expected_numbers.pop_front();
                compare_field("is_negative", longint'(want.is_negative),
                              longint'(got.is_negative));
                compare_field("significand", longint'(want.significand),
                              longint'(got.significand));
                compare_field("dec_exponent", longint'($signed(want.dec_exponent)),
                              longint'($signed(got.dec_exponent)));
                compare_field("found_digits", longint'(want.found_digits),
                              longint'(got.found_digits));
                compare_field("digits_cut", longint'(want.digits_cut),
                              longint'(got.digits_cut));
                compare_field("exp_clipped", longint'(want.exp_clipped),
                              longint'(got.exp_clipped));
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] char_code
    logic        s_axis_tlast;   // line_end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [0] is_negative, [60:1] significand, [75:61] dec_exponent,
    // [76] found_digits, [77] digits_cut, [78] exp_clipped, [79] zero
    logic [79:0] m_axis_tdata;

    number_scoreboard sb;
    logic [7:0]       line_chars[$];
    bit               idle_on;
    bit               hold_rx;

    decimal_number_text_parser
    #(
        .MAX_SIG_DIGITS (MAX_SIG_DIGITS),
        .MAX_EXP_VALUE  (MAX_EXP_VALUE)
    )
    dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Both handshakes are sampled here with their values from before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_number(dtp_pkg::dtp_result_t'(m_axis_tdata[78:0]));
            if (s_axis_tvalid && s_axis_tready)
                sb.parse_char(s_axis_tdata, s_axis_tlast);
        end
    end

    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_rx)
            begin
                hold_rx = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_pending_line();
        for (int i = 0; i < line_chars.size(); i++)
            send_char(line_chars[i], i == line_chars.size() - 1);
        line_chars = {};
    endtask

    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++)
            line_chars.push_back(s[i]);
        send_pending_line();
    endtask

    function automatic logic [7:0] random_digit();
        // Zeros come often so that leading-zero handling is exercised.
        if ($urandom_range(0, 3) == 0)
            return dtp_pkg::CH_ZERO;
        return dtp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    initial
    begin
        int kind;
        int count;
        int random_chars;
        sb            = new();
        idle_on       = 1'b1;
        hold_rx       = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_line("0");
        send_line(" \t-12.5e+3");
        send_line("+.000123E-7");
        send_line("1234567890123456789012");
        send_line("0.12345678901234567890123");
        send_line("000000000000000000000007");
        send_line("1e9999");
        send_line("1e10000");
        send_line("e5");
        send_line("-");
        send_line(".");
        send_line("12e");
        send_line("3.4x99");
        send_line("1.2.3");
        send_line("1e 5");
        send_line("5e+-3");
        send_line("-0");
        // Every whitespace code before a digit, then a line of whitespace only.
        for (int c = int'(dtp_pkg::CH_TAB); c <= int'(dtp_pkg::CH_CR); c++)
            send_char(8'(c), 1'b0);
        send_char(dtp_pkg::CH_SPACE, 1'b0);
        send_char(dtp_pkg::CH_NINE, 1'b1);
        send_char(dtp_pkg::CH_TAB, 1'b0);
        send_char(dtp_pkg::CH_SPACE, 1'b1);
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b1);

        hold_rx      = 1'b1;
        random_chars = 0;
        while (random_chars < RANDOM_CHARS)
        begin
            if (random_chars > CALM_CHARS)
                idle_on = 1'b0;
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                repeat ($urandom_range(1, 6))
                    line_chars.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3))
                        line_chars.push_back($urandom_range(0, 5) == 5 ?
                                             dtp_pkg::CH_SPACE :
                                             dtp_pkg::CH_TAB + 8'($urandom_range(0, 4)));
                case ($urandom_range(0, 3))
                    1: line_chars.push_back(dtp_pkg::CH_MINUS);
                    2: line_chars.push_back(dtp_pkg::CH_PLUS);
                    default: ;
                endcase
                count = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 24)
                                                    : $urandom_range(0, 5);
                repeat (count)
                    line_chars.push_back(random_digit());
                if ($urandom_range(0, 1) == 1)
                begin
                    line_chars.push_back(dtp_pkg::CH_POINT);
                    count = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 24)
                                                        : $urandom_range(0, 5);
                    repeat (count)
                        line_chars.push_back(random_digit());
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    line_chars.push_back($urandom_range(0, 1) ? dtp_pkg::CH_UP_E
                                                              : dtp_pkg::CH_LO_E);
                    case ($urandom_range(0, 2))
                        1: line_chars.push_back(dtp_pkg::CH_MINUS);
                        2: line_chars.push_back(dtp_pkg::CH_PLUS);
                        default: ;
                    endcase
                    count = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7)
                                                        : $urandom_range(0, 3);
                    repeat (count)
                        line_chars.push_back(random_digit());
                end
                if (kind == 1)
                    line_chars.insert($urandom_range(0, line_chars.size()),
                                      8'($urandom_range(0, 255)));
                if (kind == 2)
                    repeat ($urandom_range(1, 3))
                        line_chars.push_back(8'($urandom_range(0, 255)));
            end
            if (line_chars.size() == 0)
                line_chars.push_back(8'($urandom_range(0, 255)));
            random_chars = random_chars + line_chars.size();
            send_pending_line();
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        while (sb.expected_numbers.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
